// ===== rtl/core/bpt_pkg.sv =====
package bpt_pkg;

  // request kinds
  localparam logic [1:0] KIND_INSERT     = 2'd0;
  localparam logic [1:0] KIND_DELETE     = 2'd1;
  localparam logic [1:0] KIND_REMOVE_ALL = 2'd2;
  localparam logic [1:0] KIND_NOP        = 2'd3;

  localparam logic [31:0] TRAP_BASE  = 32'h0ce0_0000;
  localparam logic [31:0] TRAP_MASK  = 32'h0000_ffff;
  localparam logic [3:0]  MAX_LENGTH = 4'd4;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] saved;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/core/bpt_if.sv =====
interface bpt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] address;
  logic [3:0]  length;
  logic [31:0] memory_word;

  modport source (output valid, kind, address, length, memory_word, input ready);
  modport sink (input valid, kind, address, length, memory_word, output ready);
endinterface

interface bpt_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        write_valid;
  logic [31:0] write_address;
  logic [31:0] write_data;
  logic        last;

  modport source (output valid, status, write_valid, write_address, write_data, last,
                  input ready);
  modport sink (input valid, status, write_valid, write_address, write_data, last,
                output ready);
endinterface

// ===== rtl/core/bpt_cell.sv =====
module bpt_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  bpt_pkg::entry_t din,
  input  logic            load,
  input  bpt_pkg::entry_t load_data,
  output bpt_pkg::entry_t q
);

  bpt_pkg::entry_t entry;

  // direct load wins over the ring shift
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (load) begin
      entry <= load_data;
    end else if (shift) begin
      entry <= din;
    end
  end

  assign q = entry;

endmodule

// ===== rtl/core/breakpoint_patch_table.sv =====
// channel | dir | payload                                             | note
// req     | in  | kind, address, length, memory_word                  | one command per beat
// rsp     | out | status, write_valid, write_address, write_data, last| 1..ENTRIES beats/command
//
// a command is accepted, then the cell ring rotates once past its head, and then the
// final beat is posted and the chosen cell written
// remove-all stalls the ring while the response register is held by the sink
// reset clears every cell (all slots free), the sequencer and the response register
// req is ready again as soon as the final beat sits in the response register
module breakpoint_patch_table #(
  parameter int ENTRIES = 32
) (
  input  logic clk,
  input  logic rst,
  bpt_req_if.sink   req,
  bpt_rsp_if.source rsp
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  bpt_pkg::state_t state, state_next;

  // latched command
  logic [1:0]  op_kind;
  logic [31:0] op_address;
  logic [3:0]  op_length;
  logic [31:0] op_word;

  // slot currently sitting in cell 0
  logic [IDX_W-1:0] idx;

  // scan results
  logic             found_hit;
  logic [IDX_W-1:0] found_idx;
  logic [31:0]      found_word;
  logic             free_hit;
  logic [IDX_W-1:0] free_idx;

  // remove-all keeps one restore beat back so the final one can carry last
  bpt_pkg::entry_t held;
  logic            held_valid;

  // response register
  logic        rsp_valid;
  logic        rsp_status;
  logic        rsp_wv;
  logic [31:0] rsp_wa;
  logic [31:0] rsp_wd;
  logic        rsp_last;

  // cell ring
  bpt_pkg::entry_t cell_q [ENTRIES];
  bpt_pkg::entry_t head;
  bpt_pkg::entry_t tail_in;
  logic            head_busy;

  logic            accept;
  logic            out_free;
  logic            advance;
  logic            out_load;
  logic            out_status;
  logic            out_wv;
  logic [31:0]     out_wa;
  logic [31:0]     out_wd;
  logic            out_last;
  logic            apply_en;
  logic [IDX_W-1:0] apply_idx;
  bpt_pkg::entry_t apply_data;

  logic is_ra;
  logic bad_len;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == bpt_pkg::ST_IDLE);
  assign out_free  = !rsp_valid || rsp.ready;

  assign is_ra   = (op_kind == bpt_pkg::KIND_REMOVE_ALL);
  assign bad_len = (op_length > bpt_pkg::MAX_LENGTH);

  assign head      = cell_q[0];
  assign head_busy = (head.saved != 32'd0);

  // remove-all frees the entry as it leaves the head, address is kept
  always_comb begin
    tail_in = head;
    if (is_ra && head_busy) begin
      tail_in.saved = 32'd0;
    end
  end

  // ring of cells, cell 0 is the head, the head wraps around to the tail
  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    bpt_pkg::entry_t din;
    if (k == ENTRIES - 1) begin : g_tail
      assign din = tail_in;
    end else begin : g_mid
      assign din = cell_q[k+1];
    end
    bpt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (advance),
      .din       (din),
      .load      (apply_en && (apply_idx == IDX_W'(k))),
      .load_data (apply_data),
      .q         (cell_q[k])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bpt_pkg::ST_IDLE: begin
        if (accept) state_next = bpt_pkg::ST_SCAN;
      end
      bpt_pkg::ST_SCAN: begin
        if (advance && (idx == LAST_IDX)) state_next = bpt_pkg::ST_FINISH;
      end
      bpt_pkg::ST_FINISH: begin
        if (out_free) state_next = bpt_pkg::ST_IDLE;
      end
      default: state_next = bpt_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    advance    = 1'b0;
    out_load   = 1'b0;
    out_status = 1'b0;
    out_wv     = 1'b0;
    out_wa     = 32'd0;
    out_wd     = 32'd0;
    out_last   = 1'b0;
    apply_en   = 1'b0;
    apply_idx  = '0;
    apply_data = '0;
    unique case (state)
      bpt_pkg::ST_IDLE: begin
      end
      bpt_pkg::ST_SCAN: begin
        if (is_ra && head_busy && held_valid) begin
          // a newer occupied entry shows the held one was not the last
          advance  = out_free;
          out_load = out_free;
          out_wv   = 1'b1;
          out_wa   = held.addr;
          out_wd   = held.saved;
        end else begin
          advance = 1'b1;
        end
      end
      bpt_pkg::ST_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          out_last = 1'b1;
          case (op_kind)
            bpt_pkg::KIND_REMOVE_ALL: begin
              if (held_valid) begin
                out_wv = 1'b1;
                out_wa = held.addr;
                out_wd = held.saved;
              end
            end
            bpt_pkg::KIND_INSERT: begin
              if (bad_len) begin
                out_status = 1'b1;
              end else if (found_hit) begin
                // already present: no-op
              end else if (!free_hit) begin
                out_status = 1'b1;
              end else begin
                out_wv     = 1'b1;
                out_wa     = op_address;
                out_wd     = bpt_pkg::TRAP_BASE
                           + (32'(free_idx) & bpt_pkg::TRAP_MASK);
                apply_en   = 1'b1;
                apply_idx  = free_idx;
                apply_data = '{addr: op_address, saved: op_word};
              end
            end
            bpt_pkg::KIND_DELETE: begin
              if (bad_len) begin
                out_status = 1'b1;
              end else if (found_hit) begin
                out_wv     = 1'b1;
                out_wa     = op_address;
                out_wd     = found_word;
                apply_en   = 1'b1;
                apply_idx  = found_idx;
                apply_data = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bpt_pkg::ST_IDLE;
      held_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        held_valid <= 1'b0;
      end else if ((state == bpt_pkg::ST_SCAN) && advance && is_ra && head_busy) begin
        held_valid <= 1'b1;
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // command latch, scan trackers and response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind    <= req.kind;
      op_address <= req.address;
      op_length  <= req.length;
      op_word    <= req.memory_word;
      idx        <= '0;
      found_hit  <= 1'b0;
      free_hit   <= 1'b0;
    end else if ((state == bpt_pkg::ST_SCAN) && advance) begin
      idx <= idx + 1'b1;
      if (is_ra && head_busy) begin
        held <= head;
      end
      // highest matching occupied slot wins
      if (head_busy && (head.addr == op_address)) begin
        found_hit  <= 1'b1;
        found_idx  <= idx;
        found_word <= head.saved;
      end
      // lowest free slot
      if (!head_busy && !free_hit) begin
        free_hit <= 1'b1;
        free_idx <= idx;
      end
    end
    if (out_load) begin
      rsp_status <= out_status;
      rsp_wv     <= out_wv;
      rsp_wa     <= out_wa;
      rsp_wd     <= out_wd;
      rsp_last   <= out_last;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.write_valid   = rsp_wv;
  assign rsp.write_address = rsp_wa;
  assign rsp.write_data    = rsp_wd;
  assign rsp.last          = rsp_last;

endmodule

// ===== bench/breakpoint_patch_table_checker.sv =====
module breakpoint_patch_table_checker #(
  parameter int ENTRIES = 32
) (
  input  logic clk,
  input  logic rst,
  bpt_req_if   req,
  bpt_rsp_if   rsp,
  output int   mismatches,
  output int   pending
);

  typedef struct packed {
    logic        status;
    logic        write_valid;
    logic [31:0] write_address;
    logic [31:0] write_data;
    logic        last;
  } patch_beat_t;

  // shadow copy of the breakpoint table
  logic [31:0] bp_address [ENTRIES];
  logic [31:0] bp_saved   [ENTRIES];

  patch_beat_t expected_beats [$];
  int          error_count = 0;

  function automatic patch_beat_t make_beat(input logic status, input logic write_valid,
                                            input logic [31:0] write_address,
                                            input logic [31:0] write_data, input logic last);
    patch_beat_t beat;
    beat.status        = status;
    beat.write_valid   = write_valid;
    beat.write_address = write_address;
    beat.write_data    = write_data;
    beat.last          = last;
    return beat;
  endfunction

  function automatic void predict_patches(input logic [1:0] kind, input logic [31:0] address,
                                          input logic [3:0] length,
                                          input logic [31:0] memory_word);
    int          hit;
    int          free_slot;
    int          restored;
    patch_beat_t tail;
    hit       = -1;
    free_slot = -1;
    restored  = 0;
    if (kind == bpt_pkg::KIND_REMOVE_ALL) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (bp_saved[i] != '0) begin
          expected_beats.push_back(make_beat(1'b0, 1'b1, bp_address[i], bp_saved[i], 1'b0));
          bp_saved[i] = '0;
          restored++;
        end
      end
      if (restored == 0) begin
        expected_beats.push_back(make_beat(1'b0, 1'b0, '0, '0, 1'b1));
      end else begin
        tail      = expected_beats.pop_back();
        tail.last = 1'b1;
        expected_beats.push_back(tail);
      end
    end else if (kind == bpt_pkg::KIND_NOP) begin
      expected_beats.push_back(make_beat(1'b0, 1'b0, '0, '0, 1'b1));
    end else if (length > bpt_pkg::MAX_LENGTH) begin
      expected_beats.push_back(make_beat(1'b1, 1'b0, '0, '0, 1'b1));
    end else begin
      // downward walk: stop at an occupied match, remember the lowest free slot seen
      for (int i = ENTRIES - 1; i >= 0; i--) begin
        if (bp_saved[i] == '0) begin
          free_slot = i;
        end else if (bp_address[i] == address) begin
          hit = i;
          break;
        end
      end
      if (kind == bpt_pkg::KIND_INSERT) begin
        if (hit >= 0) begin
          expected_beats.push_back(make_beat(1'b0, 1'b0, '0, '0, 1'b1));
        end else if (free_slot < 0) begin
          expected_beats.push_back(make_beat(1'b1, 1'b0, '0, '0, 1'b1));
        end else begin
          expected_beats.push_back(make_beat(1'b0, 1'b1, address,
                                             bpt_pkg::TRAP_BASE
                                             + (32'(free_slot) & bpt_pkg::TRAP_MASK),
                                             1'b1));
          bp_address[free_slot] = address;
          bp_saved[free_slot]   = memory_word;
        end
      end else begin
        if (hit < 0) begin
          expected_beats.push_back(make_beat(1'b0, 1'b0, '0, '0, 1'b1));
        end else begin
          expected_beats.push_back(make_beat(1'b0, 1'b1, address, bp_saved[hit], 1'b1));
          bp_address[hit] = '0;
          bp_saved[hit]   = '0;
        end
      end
    end
  endfunction

  function automatic void check_beat(input patch_beat_t seen);
    patch_beat_t want;
    logic        bad;
    if (expected_beats.size() == 0) begin
      if (error_count < 10) begin
        $display("%0t: unexpected rsp beat st=%0b wv=%0b wa=%h wd=%h last=%0b", $realtime,
                 seen.status, seen.write_valid, seen.write_address, seen.write_data,
                 seen.last);
      end
      error_count++;
    end else begin
      want = expected_beats.pop_front();
      bad  = (seen.status !== want.status) || (seen.write_valid !== want.write_valid) ||
             (seen.write_address !== want.write_address) ||
             (seen.write_data !== want.write_data) || (seen.last !== want.last);
      if (bad) begin
        if (error_count < 10) begin
          $display("%0t: rsp beat differs: exp st=%0b wv=%0b wa=%h wd=%h last=%0b", $realtime,
                   want.status, want.write_valid, want.write_address, want.write_data,
                   want.last);
          $display("%0t:                   got st=%0b wv=%0b wa=%h wd=%h last=%0b", $realtime,
                   seen.status, seen.write_valid, seen.write_address, seen.write_data,
                   seen.last);
        end
        error_count++;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        bp_address[i] = '0;
        bp_saved[i]   = '0;
      end
      expected_beats.delete();
    end else begin
      if (req.valid && req.ready) begin
        predict_patches(req.kind, req.address, req.length, req.memory_word);
      end
      if (rsp.valid && rsp.ready) begin
        check_beat(make_beat(rsp.status, rsp.write_valid, rsp.write_address, rsp.write_data,
                             rsp.last));
      end
    end
    pending    <= expected_beats.size();
    mismatches <= error_count;
  end

endmodule

// ===== bench/breakpoint_patch_table_tb.sv =====
module breakpoint_patch_table_tb;

  localparam int ENTRIES         = 32;
  localparam int RANDOM_COMMANDS = 455;
  localparam int POOL_SIZE       = 48;
  localparam int HOLD_CYCLES     = 400;
  // extra idle time after the drain, scaled to the length of one command
  localparam int DRAIN_CYCLES    = 4 * (ENTRIES + 2);
  // ~500 commands, each up to 32 beats behind a stalling sink plus its own ring
  // rotation and sender gaps, fit well inside this limit
  localparam int CYCLE_LIMIT     = 400000;

  logic clk = 1'b0;
  logic rst;

  bpt_req_if req ();
  bpt_rsp_if rsp ();

  int mismatches;
  int pending;
  int cycle_count = 0;

  // quiet: no idling on either side; hold_request: sink holds off for a long stretch
  bit quiet        = 1'b0;
  bit hold_request = 1'b0;

  // small address pool so that inserts and deletes hit each other often
  logic [31:0] addr_pool [POOL_SIZE];

  always #5 clk = ~clk;

  breakpoint_patch_table #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  breakpoint_patch_table_checker #(
    .ENTRIES(ENTRIES)
  ) i_checker (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .mismatches(mismatches),
    .pending   (pending)
  );

  // offer one command beat and wait until it is taken
  // valid is left high so back-to-back beats never toggle it within a step
  task automatic send_command(input logic [1:0] kind, input logic [31:0] address,
                              input logic [3:0] length, input logic [31:0] memory_word);
    while (!quiet && $urandom_range(99) < 7) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.kind        <= kind;
    req.address     <= address;
    req.length      <= length;
    req.memory_word <= memory_word;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // stop offering and wait until every expected beat has come back
  task automatic pause_until_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // response side: random back-pressure, quiet stretches, one long hold-off
  initial begin : sink_side
    int hold_left;
    hold_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
        rsp.ready <= 1'b0;
      end else if (quiet) begin
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= ($urandom_range(99) >= 7);
      end
    end
  end

  // watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int          pick;
    logic [1:0]  kind;
    logic [31:0] address;
    logic [3:0]  length;
    logic [31:0] memory_word;

    rst             <= 1'b1;
    req.valid       <= 1'b0;
    req.kind        <= bpt_pkg::KIND_INSERT;
    req.address     <= '0;
    req.length      <= '0;
    req.memory_word <= '0;

    for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom;
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hffff_ffff;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    // absent delete and remove-all on an empty table
    send_command(bpt_pkg::KIND_DELETE, 32'h0000_1234, 4'd0, 32'h0);
    send_command(bpt_pkg::KIND_REMOVE_ALL, 32'hffff_ffff, 4'd15, 32'hffff_ffff);
    // extremes of address, memory word and allowed length
    send_command(bpt_pkg::KIND_INSERT, 32'h0000_0000, 4'd0, 32'hffff_ffff);
    send_command(bpt_pkg::KIND_INSERT, 32'hffff_ffff, 4'd4, 32'h0000_0001);
    // already present insert
    send_command(bpt_pkg::KIND_INSERT, 32'h0000_0000, 4'd2, 32'h5555_5555);
    // bad length on insert and on delete, table left alone
    send_command(bpt_pkg::KIND_INSERT, 32'h0000_4000, 4'd5, 32'haaaa_aaaa);
    send_command(bpt_pkg::KIND_INSERT, 32'h0000_4000, 4'd15, 32'haaaa_aaaa);
    send_command(bpt_pkg::KIND_DELETE, 32'hffff_ffff, 4'd15, 32'h0);
    // zero saved word: trap written, slot stays free and is taken again next
    send_command(bpt_pkg::KIND_INSERT, 32'h0000_1000, 4'd4, 32'h0000_0000);
    send_command(bpt_pkg::KIND_INSERT, 32'h0000_2000, 4'd1, 32'h1234_5678);
    // the zero-word address must not match on delete
    send_command(bpt_pkg::KIND_DELETE, 32'h0000_1000, 4'd4, 32'h0);
    // delete restores, second delete is a no-op
    send_command(bpt_pkg::KIND_DELETE, 32'h0000_0000, 4'd3, 32'h0);
    send_command(bpt_pkg::KIND_DELETE, 32'h0000_0000, 4'd3, 32'h0);
    // no-op kind with every field set
    send_command(bpt_pkg::KIND_NOP, 32'hffff_ffff, 4'd15, 32'hffff_ffff);
    // remove-all with two occupied slots, then with none
    send_command(bpt_pkg::KIND_REMOVE_ALL, 32'h0, 4'd0, 32'h0);
    send_command(bpt_pkg::KIND_REMOVE_ALL, 32'h0, 4'd0, 32'h0);
    pause_until_drained();

    // ---- fill the table, overflow it, then flush it in one remove-all ----
    for (int i = 0; i < ENTRIES; i++) begin
      send_command(bpt_pkg::KIND_INSERT, addr_pool[i], 4'($urandom_range(4)),
                   $urandom | 32'h1);
    end
    send_command(bpt_pkg::KIND_INSERT, addr_pool[ENTRIES + 3], 4'd4, 32'h0bad_cafe);
    send_command(bpt_pkg::KIND_INSERT, addr_pool[0], 4'd0, 32'h1);
    send_command(bpt_pkg::KIND_REMOVE_ALL, $urandom, 4'($urandom), $urandom);

    // ---- random part ----
    for (int n = 0; n < RANDOM_COMMANDS; n++) begin
      // stretch without any idling on either side
      quiet = (n >= 200 && n < 280);
      // long sink hold-off while commands keep coming, so the block backs up
      if (n == 120) hold_request = 1'b1;
      if (n == 60 || n == 330) pause_until_drained();

      pick        = $urandom_range(99);
      address     = addr_pool[$urandom_range(POOL_SIZE - 1)];
      length      = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 5))
                                             : 4'($urandom_range(4));
      memory_word = ($urandom_range(19) == 0) ? 32'h0 : $urandom;
      if (pick < 45) begin
        kind = bpt_pkg::KIND_INSERT;
      end else if (pick < 80) begin
        kind = bpt_pkg::KIND_DELETE;
        if ($urandom_range(9) == 0) address = $urandom;
      end else if (pick < 90) begin
        kind        = bpt_pkg::KIND_REMOVE_ALL;
        address     = $urandom;
        length      = 4'($urandom);
        memory_word = $urandom;
      end else if (pick < 95) begin
        kind        = bpt_pkg::KIND_NOP;
        address     = $urandom;
        length      = 4'($urandom);
        memory_word = $urandom;
      end else begin
        // noise: any address, any length
        kind    = 2'($urandom_range(1));
        address = $urandom;
        length  = 4'($urandom);
      end
      send_command(kind, address, length, memory_word);
    end
    quiet = 1'b0;

    // ---- wind down ----
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
